FILE: src/cave_pkg.sv
// cave_pkg: shared constants, types and helpers for the cave automaton block
// used by cave_row_unit and cave_cellular_automaton_step
package cave_pkg;

   // grid geometry
   localparam int MAX_COLS  = 64;
   localparam int MAX_ROWS  = 64;
   localparam int COL_W     = $clog2(MAX_COLS);
   localparam int ROW_W     = $clog2(MAX_ROWS);
   // one ram word is one grid row, the top address bit selects the bank
   localparam int ADDR_W    = ROW_W + 1;
   localparam int RAM_DEPTH = 2 ** ADDR_W;

   // sweep step counter runs 0 .. MAX_ROWS + 1
   localparam int STEP_W    = $clog2(MAX_ROWS + 2);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAX_ROWS + 1);
   localparam logic [STEP_W-1:0] STEP_ROWS = STEP_W'(MAX_ROWS);

   // item field widths
   localparam int FUNC_W    = 2;
   localparam int IO_W      = 6;
   localparam int GEN_W     = 16;
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 1;

   // common width for unsigned compares of counters, coordinates and registers
   localparam int CMP_A_W   = (STEP_W > CFG_W) ? STEP_W : CFG_W;
   localparam int CMP_W     = ((CMP_A_W > COL_W) ? CMP_A_W : COL_W) + 2;

   // neighbor count and rule thresholds
   localparam int NBR_W     = 4;
   localparam logic [NBR_W-1:0] BIRTH_MIN   = NBR_W'(5);
   localparam logic [NBR_W-1:0] SURVIVE_MIN = NBR_W'(4);

   // register reset value
   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = CSR_IDX_W'(1);

   typedef logic [MAX_COLS-1:0] row_type;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_RUN   = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_NOP   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ACCESS,
      S_GEN,
      S_RESP
   } state_type;

   // one bit per column, set for columns inside the grid in use
   function automatic row_type col_mask(input logic [CFG_W-1:0] cols);
      row_type m;
      m = '0;
      for (int c = 0; c < MAX_COLS; c++) begin
         m[c] = CMP_W'(c) < CMP_W'(cols);
      end
      return m;
   endfunction

endpackage

FILE: src/cave_ram.sv
// cave_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module cave_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/cave_row_unit.sv
// cave_row_unit: one lane per column, computes the next value of a whole grid row
// depends on cave_pkg
module cave_row_unit
   import cave_pkg::*;
(
   input  row_type col_live,    // columns inside the grid in use
   input  logic    mid_live,    // middle row inside the grid in use
   input  row_type above_row,   // already masked, dead outside the grid
   input  row_type mid_row,     // raw stored row
   input  row_type below_row,   // already masked, dead outside the grid
   output row_type mid_masked,
   output row_type next_row
);

   logic [MAX_COLS+1:0] ap;
   logic [MAX_COLS+1:0] mp;
   logic [MAX_COLS+1:0] bp;

   // pad with dead cells at both edges
   assign mid_masked = mid_live ? (mid_row & col_live) : '0;
   assign ap = {1'b0, above_row, 1'b0};
   assign mp = {1'b0, mid_masked, 1'b0};
   assign bp = {1'b0, below_row, 1'b0};

   always_comb begin
      logic [NBR_W-1:0] cnt;
      cnt = '0;
      next_row = mid_row;
      for (int c = 0; c < MAX_COLS; c++) begin
         cnt = NBR_W'(ap[c]) + NBR_W'(ap[c+1]) + NBR_W'(ap[c+2])
             + NBR_W'(mp[c])                   + NBR_W'(mp[c+2])
             + NBR_W'(bp[c]) + NBR_W'(bp[c+1]) + NBR_W'(bp[c+2]);
         // cells outside the grid in use are copied unchanged
         if (mid_live && col_live[c]) begin
            next_row[c] = mid_row[c] ? (cnt >= SURVIVE_MIN) : (cnt >= BIRTH_MIN);
         end
      end
   end

endmodule

FILE: src/cave_cellular_automaton_step.sv
// cave_cellular_automaton_step: cave automaton (4-5 rule) on a double-banked row ram
// a cell write or read in range passes through the access and response states, a no-op,
// an off-grid cell or a run of zero generations goes straight to the response state
// items are taken one at a time, a new one only when the last result is registered; a
// generation sweeps one ram row per cycle. reset: synchronous; a clearing pass zeroes all
// RAM_DEPTH words of both banks, no item is taken meanwhile; registers reset to 64, bank a active
module cave_cellular_automaton_step
   import cave_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request items
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,   // col[5:0], row[11:6], cell_in[12], generations[28:13]
   input  logic [FUNC_W-1:0]    req_tuser,   // func[1:0]
   // result items
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // cell_out[0]
   output logic                 rsp_tuser,   // off_grid[0]
   // register writes
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   // request field unpacking
   func_type          req_func;
   logic [IO_W-1:0]   req_col;
   logic [IO_W-1:0]   req_row;
   logic              req_cell;
   logic [GEN_W-1:0]  req_gens;
   logic              req_accept;
   logic              req_in_range;
   logic              req_is_cell;

   assign req_func = func_type'(req_tuser);
   assign req_col  = req_tdata[IO_W-1:0];
   assign req_row  = req_tdata[2*IO_W-1:IO_W];
   assign req_cell = req_tdata[2*IO_W];
   assign req_gens = req_tdata[2*IO_W+GEN_W:2*IO_W+1];

   // control state
   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                active_ff, active_in;
   logic [CFG_W-1:0]    cols_ff, cols_in;
   logic [CFG_W-1:0]    rows_ff, rows_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;

   // payload state
   func_type            func_ff, func_in;
   logic [IO_W-1:0]     col_ff, col_in;
   logic [IO_W-1:0]     row_ff, row_in;
   logic                cell_ff, cell_in;
   logic [GEN_W-1:0]    gen_left_ff, gen_left_in;
   row_type             above_ff, above_in;
   row_type             mid_ff, mid_in;
   logic                res_cell_ff, res_cell_in;
   logic                res_oor_ff, res_oor_in;
   logic                rsp_cell_ff, rsp_cell_in;
   logic                rsp_oor_ff, rsp_oor_in;

   // ram port
   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   row_type             ram_wr_data;
   logic                ram_rd_en;
   logic [ADDR_W-1:0]   ram_rd_addr;
   row_type             ram_rd_data;

   // sweep datapath
   row_type             cols_live;
   logic [STEP_W-1:0]   mid_idx;
   logic [STEP_W-1:0]   below_idx;
   logic                mid_live;
   logic                below_live;
   row_type             below_row;
   row_type             mid_masked;
   row_type             next_row;
   row_type             cell_row;
   logic [COL_W-1:0]    col_idx;
   logic                rsp_slot_free;

   assign req_tready    = (state_ff == S_IDLE);
   assign req_accept    = req_tvalid && req_tready;
   assign rsp_slot_free = !rsp_tvalid_ff || rsp_tready;

   // a coordinate lies inside when below both the register and the store size
   assign req_is_cell  = (req_func == FUNC_WRITE) || (req_func == FUNC_READ);
   assign req_in_range = (CMP_W'(req_col) < CMP_W'(cols_ff))
                      && (CMP_W'(req_col) < CMP_W'(MAX_COLS))
                      && (CMP_W'(req_row) < CMP_W'(rows_ff))
                      && (CMP_W'(req_row) < CMP_W'(MAX_ROWS));

   // sweep window: step s reads row s, computes row s-2 from rows s-3, s-2, s-1
   assign cols_live  = col_mask(cols_ff);
   assign mid_idx    = step_ff - STEP_W'(2);
   assign below_idx  = step_ff - STEP_W'(1);
   assign mid_live   = (CMP_W'(mid_idx) < CMP_W'(rows_ff))
                    && (CMP_W'(mid_idx) < CMP_W'(MAX_ROWS));
   assign below_live = (step_ff != '0)
                    && (CMP_W'(below_idx) < CMP_W'(rows_ff))
                    && (CMP_W'(below_idx) < CMP_W'(MAX_ROWS));
   assign below_row  = below_live ? (ram_rd_data & cols_live) : '0;

   cave_row_unit u_row_unit (
      .col_live   (cols_live),
      .mid_live   (mid_live),
      .above_row  (above_ff),
      .mid_row    (mid_ff),
      .below_row  (below_row),
      .mid_masked (mid_masked),
      .next_row   (next_row)
   );

   // single cell update of the row read back from the active bank
   assign col_idx = COL_W'(col_ff);
   always_comb begin
      cell_row = ram_rd_data;
      cell_row[col_idx] = cell_ff;
   end

   cave_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (RAM_DEPTH)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == {ADDR_W{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               priority if (req_is_cell && req_in_range) begin
                  state_in = S_ACCESS;
               end else if ((req_func == FUNC_RUN) && (req_gens != '0)) begin
                  state_in = S_GEN;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_ACCESS: begin
            state_in = S_RESP;
         end
         S_GEN: begin
            if ((step_ff == STEP_LAST) && (gen_left_ff == GEN_W'(1))) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // datapath and ram control
   always_comb begin
      clr_in        = clr_ff;
      step_in       = step_ff;
      active_in     = active_ff;
      cols_in       = cols_ff;
      rows_in       = rows_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      func_in       = func_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      cell_in       = cell_ff;
      gen_left_in   = gen_left_ff;
      above_in      = above_ff;
      mid_in        = mid_ff;
      res_cell_in   = res_cell_ff;
      res_oor_in    = res_oor_ff;
      rsp_cell_in   = rsp_cell_ff;
      rsp_oor_in    = rsp_oor_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = '0;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;

      // registers are taken in any state
      if (csr_wr_en) begin
         priority if (csr_index == CSR_COLS) begin
            cols_in = csr_wdata;
         end else if (csr_index == CSR_ROWS) begin
            rows_in = csr_wdata;
         end
      end

      unique case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + ADDR_W'(1);
         end
         S_IDLE: begin
            if (req_accept) begin
               func_in     = req_func;
               col_in      = req_col;
               row_in      = req_row;
               cell_in     = req_cell;
               gen_left_in = req_gens;
               step_in     = '0;
               res_cell_in = 1'b0;
               res_oor_in  = req_is_cell && !req_in_range;
               // fetch the row that holds the addressed cell
               ram_rd_en   = req_is_cell && req_in_range;
               ram_rd_addr = {active_ff, ROW_W'(req_row)};
            end
         end
         S_ACCESS: begin
            if (func_ff == FUNC_WRITE) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = {active_ff, ROW_W'(row_ff)};
               ram_wr_data = cell_row;
            end else begin
               res_cell_in = ram_rd_data[col_idx];
            end
         end
         S_GEN: begin
            ram_rd_en   = step_ff < STEP_ROWS;
            ram_rd_addr = {active_ff, ROW_W'(step_ff)};
            if (step_ff == '0) begin
               above_in = '0;
               mid_in   = '0;
            end else begin
               above_in = mid_masked;
               mid_in   = ram_rd_data;
            end
            // new row goes into the other bank
            if (step_ff >= STEP_W'(2)) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = {~active_ff, ROW_W'(mid_idx)};
               ram_wr_data = next_row;
            end
            if (step_ff == STEP_LAST) begin
               active_in   = ~active_ff;
               gen_left_in = gen_left_ff - GEN_W'(1);
               step_in     = '0;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_RESP: begin
            if (rsp_slot_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_cell_in   = res_cell_ff;
               rsp_oor_in    = res_oor_ff;
            end
         end
         default: begin
            clr_in = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         step_ff       <= '0;
         active_ff     <= 1'b0;
         cols_ff       <= CFG_RESET;
         rows_ff       <= CFG_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         step_ff       <= step_in;
         active_ff     <= active_in;
         cols_ff       <= cols_in;
         rows_ff       <= rows_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      cell_ff     <= cell_in;
      gen_left_ff <= gen_left_in;
      above_ff    <= above_in;
      mid_ff      <= mid_in;
      res_cell_ff <= res_cell_in;
      res_oor_ff  <= res_oor_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_oor_ff  <= rsp_oor_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'b0, rsp_cell_ff};
   assign rsp_tuser  = rsp_oor_ff;

   // a generation never writes into the bank it reads from
   a_gen_writes_target: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GEN) && ram_wr_en |-> ram_wr_addr[ADDR_W-1] != active_ff)
      else $error("generation write hits the source bank");

   // the bank flips only at the end of a sweep
   a_bank_flip_on_sweep_end: assert property (@(posedge clock) disable iff (reset)
      !$stable(active_ff) |-> ($past(state_ff) == S_GEN) && ($past(step_ff) == STEP_LAST))
      else $error("active bank changed outside a sweep end");

   // a run with generations starts a sweep
   a_run_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_func == FUNC_RUN) && (req_gens != '0)
      |=> (state_ff == S_GEN) && (step_ff == '0))
      else $error("run item did not start a sweep");

   // the ram stays untouched while waiting for items
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) || (state_ff == S_RESP) |-> !ram_wr_en)
      else $error("ram write while no item in progress");

endmodule
